// ----- rtl/rom_ram_bank_controller_type1_unit_defines.svh -----
// Assertion macros shared by the bank controller RTL.
`ifndef ROM_RAM_BANK_CONTROLLER_TYPE1_UNIT_DEFINES_SVH
`define ROM_RAM_BANK_CONTROLLER_TYPE1_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define RRBC1_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define RRBC1_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/rrbc1_pkg.sv -----
// Types and constants for the type 1 ROM/RAM bank controller.
`default_nettype none

package rrbc1_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_ROM_BANKS_DEF = 128;
    localparam int MAX_RAM_BANKS_DEF = 4;

    localparam int RAM_BANK_BYTES = 8192;
    localparam int RAM_OFS_W      = 13;

    localparam int S_TDATA_W = 24;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 32;
    localparam int M_TUSER_W = 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 8;

    // Bus address map
    localparam logic [15:0] ADDR_ROM_BANKED = 16'h4000;
    localparam logic [15:0] ADDR_MODE_REG   = 16'h6000;
    localparam logic [15:0] ADDR_UNMAPPED   = 16'h8000;
    localparam logic [15:0] ADDR_RAM_BASE   = 16'hA000;
    localparam logic [15:0] ADDR_RAM_END    = 16'hC000;
    localparam logic [15:0] ADDR_SEL_LOW    = 16'h2000;

    localparam logic [3:0] RAM_EN_KEY = 4'hA;
    localparam logic [7:0] OPEN_BUS   = 8'hFF;

    // Banks that hardware skips by one on a banked read
    localparam logic [6:0] BANK_SKIP_A = 7'h20;
    localparam logic [6:0] BANK_SKIP_B = 7'h40;
    localparam logic [6:0] BANK_SKIP_C = 7'h60;

    localparam logic [7:0] ROM_COUNT_RST = 8'd2;
    localparam logic [2:0] RAM_COUNT_RST = 3'd0;

    typedef enum logic [1:0] {
        SRC_ROM   = 2'd0,
        SRC_RAM   = 2'd1,
        SRC_OPEN  = 2'd2,
        SRC_WRITE = 2'd3
    } src_t;

    typedef enum logic {
        CMD_READ  = 1'b0,
        CMD_WRITE = 1'b1
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROM_BANK_COUNT = 1'b0,
        CFG_RAM_BANK_COUNT = 1'b1
    } cfg_idx_t;

endpackage

`default_nettype wire

// ----- rtl/rom_ram_bank_controller_type1_unit.sv -----
// An accepted item passes the decode stage and then the output register; the cartridge RAM read port
// is registered in the decode stage. Throughput: one item per cycle unless the output stalls.
// Input stays ready while a result waits, as long as the decode stage is free.
// Reset (aresetn low, synchronous) sets ROM bank 1, selector 0, RAM bank 0, RAM disabled,
// mode 0, bank counts 2 and 0; cartridge RAM contents are not cleared.
`default_nettype none

`include "rom_ram_bank_controller_type1_unit_defines.svh"

module rom_ram_bank_controller_type1_unit #(
    parameter int MAX_ROM_BANKS = rrbc1_pkg::MAX_ROM_BANKS_DEF,
    parameter int MAX_RAM_BANKS = rrbc1_pkg::MAX_RAM_BANKS_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // config write channel
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [rrbc1_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [rrbc1_pkg::CFG_DATA_W-1:0] cfg_data,
    // bus access items
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // [0] command
    input  wire logic [rrbc1_pkg::S_TUSER_W-1:0]  s_tuser,
    // [15:0] address, [23:16] write_data
    input  wire logic [rrbc1_pkg::S_TDATA_W-1:0]  s_tdata,
    // results
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // [1:0] source
    output logic [rrbc1_pkg::M_TUSER_W-1:0]       m_tuser,
    // [20:0] rom_address, [28:21] read_data, [31:29] zero
    output logic [rrbc1_pkg::M_TDATA_W-1:0]       m_tdata
);

    localparam int RAM_DEPTH = MAX_RAM_BANKS * rrbc1_pkg::RAM_BANK_BYTES;
    localparam int RAM_AW    = $clog2(RAM_DEPTH);
    localparam logic [7:0] ROM_LIM_MAX = 8'(MAX_ROM_BANKS);
    localparam logic [2:0] RAM_LIM_MAX = 3'(MAX_RAM_BANKS);

    // configuration
    logic [7:0] rom_cnt_reg;
    logic [2:0] ram_cnt_reg;

    // bank state
    logic [6:0] active_rom_bank_reg, active_rom_bank_next;
    logic [6:0] bank_sel_reg, bank_sel_next;
    logic [1:0] active_ram_bank_reg, active_ram_bank_next;
    logic       ram_en_reg, ram_en_next;
    logic       mode_reg, mode_next;

    // decode stage
    logic                 p1_valid_reg;
    rrbc1_pkg::src_t      p1_src_reg;
    logic [20:0]          p1_rom_addr_reg;
    logic [7:0]           p1_rdata_reg;
    logic [7:0]           ram_rd_reg;

    // output stage
    logic                 m_valid_reg;
    rrbc1_pkg::src_t      m_src_reg;
    logic [20:0]          m_rom_addr_reg;
    logic [7:0]           m_rdata_reg;

    logic [7:0] ram_mem [RAM_DEPTH];

    logic                 in_accept;
    logic                 p1_advance;
    rrbc1_pkg::cmd_t      in_cmd;
    logic [15:0]          in_addr;
    logic [7:0]           in_wdata;
    logic [7:0]           rom_lim;
    logic [2:0]           ram_lim;
    logic                 ram_hit;
    logic [RAM_AW-1:0]    ram_idx;
    logic                 ram_we;
    logic                 ram_re;
    rrbc1_pkg::src_t      src_next;
    logic [20:0]          rom_addr_next;
    logic [7:0]           rdata_next;
    logic [6:0]           bumped_bank;
    logic [6:0]           sel_cand;
    logic                 sel_apply;

    assign in_cmd   = rrbc1_pkg::cmd_t'(s_tuser[0]);
    assign in_addr  = s_tdata[15:0];
    assign in_wdata = s_tdata[23:16];

    assign p1_advance = p1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready   = !p1_valid_reg || p1_advance;
    assign in_accept  = s_tvalid && s_tready;
    assign cfg_ready  = 1'b1;

    assign rom_lim = (rom_cnt_reg < ROM_LIM_MAX) ? rom_cnt_reg : ROM_LIM_MAX;
    assign ram_lim = (ram_cnt_reg < RAM_LIM_MAX) ? ram_cnt_reg : RAM_LIM_MAX;

    // RAM byte present: window hit, RAM fitted, and the bank lies inside the store
    assign ram_hit = (in_addr >= rrbc1_pkg::ADDR_RAM_BASE)
                  && (in_addr < rrbc1_pkg::ADDR_RAM_END)
                  && (ram_lim != 3'd0)
                  && ({1'b0, active_ram_bank_reg} < RAM_LIM_MAX);
    assign ram_idx = RAM_AW'({active_ram_bank_reg, in_addr[rrbc1_pkg::RAM_OFS_W-1:0]});

    assign bumped_bank = (active_rom_bank_reg == rrbc1_pkg::BANK_SKIP_A
                       || active_rom_bank_reg == rrbc1_pkg::BANK_SKIP_B
                       || active_rom_bank_reg == rrbc1_pkg::BANK_SKIP_C)
                       ? active_rom_bank_reg + 7'd1 : active_rom_bank_reg;

    always_comb begin
        active_rom_bank_next = active_rom_bank_reg;
        bank_sel_next        = bank_sel_reg;
        active_ram_bank_next = active_ram_bank_reg;
        ram_en_next          = ram_en_reg;
        mode_next            = mode_reg;
        src_next             = rrbc1_pkg::SRC_WRITE;
        rom_addr_next        = '0;
        rdata_next           = '0;
        ram_we               = 1'b0;
        ram_re               = 1'b0;
        sel_cand             = bank_sel_reg;
        sel_apply            = 1'b0;

        if (in_cmd == rrbc1_pkg::CMD_READ) begin
            if (in_addr < rrbc1_pkg::ADDR_ROM_BANKED) begin
                src_next      = rrbc1_pkg::SRC_ROM;
                rom_addr_next = 21'(in_addr);
            end else if (in_addr < rrbc1_pkg::ADDR_UNMAPPED) begin
                active_rom_bank_next = bumped_bank;
                src_next             = rrbc1_pkg::SRC_ROM;
                rom_addr_next        = {bumped_bank, in_addr[13:0]};
            end else if (ram_hit) begin
                src_next = rrbc1_pkg::SRC_RAM;
                ram_re   = 1'b1;
            end else begin
                src_next   = rrbc1_pkg::SRC_OPEN;
                rdata_next = rrbc1_pkg::OPEN_BUS;
            end
        end else begin
            if (in_addr < rrbc1_pkg::ADDR_SEL_LOW) begin
                ram_en_next = (in_wdata[3:0] == rrbc1_pkg::RAM_EN_KEY);
            end else if (in_addr < rrbc1_pkg::ADDR_ROM_BANKED) begin
                sel_cand  = {bank_sel_reg[6:5], in_wdata[4:0]};
                sel_apply = 1'b1;
            end else if (in_addr < rrbc1_pkg::ADDR_MODE_REG) begin
                if (!mode_reg) begin
                    sel_cand  = {in_wdata[1:0], bank_sel_reg[4:0]};
                    sel_apply = 1'b1;
                end else if ({1'b0, in_wdata[1:0]} < ram_lim) begin
                    active_ram_bank_next = in_wdata[1:0];
                end
            end else if (in_addr < rrbc1_pkg::ADDR_UNMAPPED) begin
                mode_next = in_wdata[0];
            end else if (ram_en_reg && ram_hit) begin
                ram_we = 1'b1;
            end
        end

        // selector at or beyond the ROM size leaves the active bank alone
        if (sel_apply) begin
            bank_sel_next = sel_cand;
            if ({1'b0, sel_cand} < rom_lim) begin
                active_rom_bank_next = (sel_cand == 7'd0) ? 7'd1 : sel_cand;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rom_cnt_reg <= rrbc1_pkg::ROM_COUNT_RST;
            ram_cnt_reg <= rrbc1_pkg::RAM_COUNT_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (rrbc1_pkg::cfg_idx_t'(cfg_index))
                rrbc1_pkg::CFG_ROM_BANK_COUNT: rom_cnt_reg <= cfg_data;
                rrbc1_pkg::CFG_RAM_BANK_COUNT: ram_cnt_reg <= cfg_data[2:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_rom_bank_reg <= 7'd1;
            bank_sel_reg        <= '0;
            active_ram_bank_reg <= '0;
            ram_en_reg          <= 1'b0;
            mode_reg            <= 1'b0;
        end else if (in_accept) begin
            active_rom_bank_reg <= active_rom_bank_next;
            bank_sel_reg        <= bank_sel_next;
            active_ram_bank_reg <= active_ram_bank_next;
            ram_en_reg          <= ram_en_next;
            mode_reg            <= mode_next;
        end
    end

    // cartridge RAM: one write or one registered read per accepted item
    always_ff @(posedge aclk) begin
        if (in_accept && ram_we) begin
            ram_mem[ram_idx] <= in_wdata;
        end
        if (in_accept && ram_re) begin
            ram_rd_reg <= ram_mem[ram_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (in_accept) begin
            p1_valid_reg <= 1'b1;
        end else if (p1_advance) begin
            p1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            p1_src_reg      <= src_next;
            p1_rom_addr_reg <= rom_addr_next;
            p1_rdata_reg    <= rdata_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (p1_advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (p1_advance) begin
            m_src_reg      <= p1_src_reg;
            m_rom_addr_reg <= p1_rom_addr_reg;
            m_rdata_reg    <= (p1_src_reg == rrbc1_pkg::SRC_RAM) ? ram_rd_reg : p1_rdata_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_src_reg;
    assign m_tdata  = {3'b000, m_rdata_reg, m_rom_addr_reg};

    `RRBC1_ASSERT_NOW(a_rom_bank_nonzero, 1'b1, active_rom_bank_reg != 7'd0,
        "active ROM bank reached zero")
    `RRBC1_ASSERT_NOW(a_stall_only_when_full, !s_tready,
        p1_valid_reg && m_valid_reg && !m_tready, "input stalled with a free stage")
    `RRBC1_ASSERT_NEXT(a_accept_fills_stage, in_accept, p1_valid_reg,
        "accepted item missing from decode stage")
    `RRBC1_ASSERT_NOW(a_rom_addr_only_rom, m_valid_reg && (m_src_reg != rrbc1_pkg::SRC_ROM),
        m_rom_addr_reg == 21'd0, "ROM address set on a non-ROM result")
    `RRBC1_ASSERT_NEXT(a_stage_holds, p1_valid_reg && m_valid_reg && !m_tready,
        p1_valid_reg && $stable(p1_src_reg), "decode stage lost an item under stall")

endmodule

`default_nettype wire

// ----- dv/tb.sv -----
// Self-checking testbench for the type 1 ROM/RAM bank controller: directed and random bus accesses.
`timescale 1ns / 100ps

module tb;

    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 4;
    localparam int LONG_HOLD    = 150;
    localparam int MAX_PRINTS   = 40;

    typedef struct packed {
        rrbc1_pkg::src_t source;
        logic [20:0]     rom_address;
        logic [7:0]      read_data;
    } bus_result_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    rrbc1_pkg::cfg_idx_t cfg_index;
    logic [7:0]  cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic        s_tuser;
    logic [23:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [1:0]  m_tuser;
    logic [31:0] m_tdata;

    // controller state as the checker sees it
    logic [6:0] cur_rom_bank;
    logic [6:0] sel_bits;
    logic [1:0] cur_ram_bank;
    logic       ram_on;
    logic       mode;
    logic [7:0] rom_count;
    logic [2:0] ram_count;
    logic [7:0] ram_image [32768];
    bit         ram_seen [32768];
    logic [12:0] written_ofs [4][$];

    bus_result_t pending_results[$];

    bit idle_bursts_on;
    int hold_req;
    int hold_left;
    int stall_left;
    int stall_cycles;
    int errors;
    int n_items, n_results, n_settings;
    int n_rom, n_ram, n_open, n_write, n_bumps;

    rom_ram_bank_controller_type1_unit uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tuser   (m_tuser),
        .m_tdata   (m_tdata)
    );

    always #5 aclk = ~aclk;

    function automatic int rom_banks();
        return (rom_count < 128) ? int'(rom_count) : 128;
    endfunction

    function automatic int ram_banks();
        return (ram_count < 4) ? int'(ram_count) : 4;
    endfunction

    // bank index is 2 bits, so a mapped byte always lands inside the 32 KiB store
    function automatic bit ram_mapped(logic [15:0] a);
        return a >= rrbc1_pkg::ADDR_RAM_BASE && a < rrbc1_pkg::ADDR_RAM_END
            && ram_banks() != 0;
    endfunction

    function automatic void apply_selector();
        if (sel_bits < rom_banks())
            cur_rom_bank = (sel_bits == 7'd0) ? 7'd1 : sel_bits;
    endfunction

    function automatic bus_result_t bank_access_result(rrbc1_pkg::cmd_t c, logic [15:0] a,
                                                       logic [7:0] d);
        bus_result_t r;
        logic [14:0] idx;
        r.source = rrbc1_pkg::SRC_WRITE;
        r.rom_address = '0;
        r.read_data = '0;
        idx = {cur_ram_bank, a[12:0]};
        if (c == rrbc1_pkg::CMD_READ) begin
            if (a < rrbc1_pkg::ADDR_ROM_BANKED) begin
                r.source = rrbc1_pkg::SRC_ROM;
                r.rom_address = {5'd0, a};
            end else if (a < rrbc1_pkg::ADDR_UNMAPPED) begin
                if (cur_rom_bank == rrbc1_pkg::BANK_SKIP_A ||
                    cur_rom_bank == rrbc1_pkg::BANK_SKIP_B ||
                    cur_rom_bank == rrbc1_pkg::BANK_SKIP_C) begin
                    cur_rom_bank = cur_rom_bank + 7'd1;
                    n_bumps++;
                end
                r.source = rrbc1_pkg::SRC_ROM;
                r.rom_address = {cur_rom_bank, a[13:0]};
            end else if (ram_mapped(a)) begin
                r.source = rrbc1_pkg::SRC_RAM;
                r.read_data = ram_image[idx];
            end else begin
                r.source = rrbc1_pkg::SRC_OPEN;
                r.read_data = rrbc1_pkg::OPEN_BUS;
            end
        end else begin
            if (a < rrbc1_pkg::ADDR_SEL_LOW) begin
                ram_on = (d[3:0] == rrbc1_pkg::RAM_EN_KEY);
            end else if (a < rrbc1_pkg::ADDR_ROM_BANKED) begin
                sel_bits = {sel_bits[6:5], d[4:0]};
                apply_selector();
            end else if (a < rrbc1_pkg::ADDR_MODE_REG) begin
                if (!mode) begin
                    sel_bits = {d[1:0], sel_bits[4:0]};
                    apply_selector();
                end else if (d[1:0] < ram_banks()) begin
                    cur_ram_bank = d[1:0];
                end
            end else if (a < rrbc1_pkg::ADDR_UNMAPPED) begin
                mode = d[0];
            end else if (ram_on && ram_mapped(a)) begin
                ram_image[idx] = d;
                if (!ram_seen[idx]) begin
                    ram_seen[idx] = 1'b1;
                    written_ofs[cur_ram_bank].push_back(a[12:0]);
                end
            end
        end
        return r;
    endfunction

    // RAM contents are undefined until written: steer reads onto written bytes
    function automatic logic [15:0] safe_ram_read(logic [15:0] a);
        int n;
        if (!ram_mapped(a) || ram_seen[{cur_ram_bank, a[12:0]}])
            return a;
        n = written_ofs[cur_ram_bank].size();
        if (n > 0)
            return rrbc1_pkg::ADDR_RAM_BASE
                 | {3'd0, written_ofs[cur_ram_bank][$urandom_range(0, n - 1)]};
        return {3'b110, a[12:0]};
    endfunction

    task automatic report_mismatch(string msg);
        errors++;
        if (errors <= MAX_PRINTS)
            $display("MISMATCH: %s", msg);
    endtask

    // receiver: random stall bursts, plus a long hold when a test asks for one
    always @(negedge aclk) begin
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (idle_bursts_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 7);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : check_results
        bus_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            n_results++;
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result %0d arrived with nothing pending", n_results));
            end else begin
                want = pending_results.pop_front();
                if (m_tuser !== want.source)
                    report_mismatch($sformatf("result %0d: source %0d, want %0d",
                        n_results, m_tuser, want.source));
                if (m_tdata[20:0] !== want.rom_address)
                    report_mismatch($sformatf("result %0d: rom_address %h, want %h",
                        n_results, m_tdata[20:0], want.rom_address));
                if (m_tdata[28:21] !== want.read_data)
                    report_mismatch($sformatf("result %0d: read_data %h, want %h",
                        n_results, m_tdata[28:21], want.read_data));
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Timeout: no handshake for %0d cycles, %0d results pending",
                STALL_LIMIT, pending_results.size());
            $display("Verification failed");
            $finish;
        end
    end

    task automatic send_access(rrbc1_pkg::cmd_t c, logic [15:0] a, logic [7:0] d);
        bus_result_t r;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser <= c;
        s_tdata <= {d, a};
        do @(posedge aclk); while (!s_tready);
        r = bank_access_result(c, a, d);
        pending_results.push_back(r);
        n_items++;
        case (r.source)
            rrbc1_pkg::SRC_ROM:   n_rom++;
            rrbc1_pkg::SRC_RAM:   n_ram++;
            rrbc1_pkg::SRC_OPEN:  n_open++;
            rrbc1_pkg::SRC_WRITE: n_write++;
            default: ;
        endcase
    endtask

    task automatic sender_gap();
        if (idle_bursts_on && $urandom_range(0, 3) == 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat ($urandom_range(0, 7)) @(negedge aclk);
        end
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_config(rrbc1_pkg::cfg_idx_t idx, logic [7:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            rrbc1_pkg::CFG_ROM_BANK_COUNT: rom_count = val;
            rrbc1_pkg::CFG_RAM_BANK_COUNT: ram_count = val[2:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_bank_counts(logic [7:0] rom, logic [2:0] ram);
        wait_idle();
        write_config(rrbc1_pkg::CFG_ROM_BANK_COUNT, rom);
        write_config(rrbc1_pkg::CFG_RAM_BANK_COUNT, {5'd0, ram});
        n_settings++;
    endtask

    // mostly cartridge-like traffic: bank switches, RAM enable, RAM and ROM reads
    task automatic random_access(output rrbc1_pkg::cmd_t c, output logic [15:0] a,
                                 output logic [7:0] d);
        int unsigned pick;
        pick = $urandom_range(0, 99);
        d = 8'($urandom);
        c = rrbc1_pkg::CMD_WRITE;
        if (pick < 18) begin
            c = rrbc1_pkg::CMD_READ;
            a = 16'($urandom_range(16'h0000, 16'h3FFF));
        end else if (pick < 38) begin
            c = rrbc1_pkg::CMD_READ;
            a = 16'($urandom_range(16'h4000, 16'h7FFF));
        end else if (pick < 58) begin
            c = rrbc1_pkg::CMD_READ;
            a = 16'($urandom_range(16'hA000, 16'hBFFF));
        end else if (pick < 73) begin
            a = 16'($urandom_range(16'hA000, 16'hBFFF));
        end else if (pick < 78) begin
            a = 16'($urandom_range(16'h0000, 16'h1FFF));
            if ($urandom_range(0, 1) == 1)
                d[3:0] = rrbc1_pkg::RAM_EN_KEY;
        end else if (pick < 86) begin
            a = 16'($urandom_range(16'h2000, 16'h3FFF));
            if ($urandom_range(0, 3) == 0)
                d[4:0] = 5'd0;
        end else if (pick < 92) begin
            a = 16'($urandom_range(16'h4000, 16'h5FFF));
        end else if (pick < 95) begin
            a = 16'($urandom_range(16'h6000, 16'h7FFF));
        end else begin
            c = rrbc1_pkg::cmd_t'($urandom_range(0, 1));
            a = 16'(($urandom_range(0, 1) == 1) ? $urandom_range(16'h8000, 16'h9FFF)
                                                : $urandom_range(16'hC000, 16'hFFFF));
        end
        if (c == rrbc1_pkg::CMD_READ)
            a = safe_ram_read(a);
    endtask

    task automatic random_items(int n);
        rrbc1_pkg::cmd_t c;
        logic [15:0] a;
        logic [7:0] d;
        repeat (n) begin
            sender_gap();
            random_access(c, a, d);
            send_access(c, a, d);
        end
    endtask

    task automatic test_directed_cases();
        // reset counts: 2 ROM banks, no RAM
        send_access(rrbc1_pkg::CMD_READ,  16'h0000, 8'h00);
        send_access(rrbc1_pkg::CMD_READ,  16'h3FFF, 8'hFF);
        send_access(rrbc1_pkg::CMD_READ,  16'h4000, 8'h00);
        send_access(rrbc1_pkg::CMD_READ,  16'h7FFF, 8'h00);
        send_access(rrbc1_pkg::CMD_WRITE, 16'h2000, 8'h01);
        send_access(rrbc1_pkg::CMD_WRITE, 16'h3FFF, 8'h1F);   // beyond the ROM, kept
        send_access(rrbc1_pkg::CMD_READ,  16'h8000, 8'h00);
        send_access(rrbc1_pkg::CMD_READ,  16'hC000, 8'h00);
        send_access(rrbc1_pkg::CMD_READ,  16'hA000, 8'h00);   // no RAM: open bus
        send_access(rrbc1_pkg::CMD_WRITE, 16'h0000, 8'h0A);
        send_access(rrbc1_pkg::CMD_WRITE, 16'hA000, 8'h5A);   // no RAM: dropped
        send_access(rrbc1_pkg::CMD_READ,  16'hBFFF, 8'h00);
        send_access(rrbc1_pkg::CMD_WRITE, 16'hFFFF, 8'hFF);
        set_bank_counts(8'd128, 3'd4);
        send_access(rrbc1_pkg::CMD_WRITE, 16'h2000, 8'h00);   // zero selects bank 1
        send_access(rrbc1_pkg::CMD_WRITE, 16'h5FFF, 8'h01);   // bank 0x20
        send_access(rrbc1_pkg::CMD_READ,  16'h4000, 8'h00);   // skips to 0x21
        send_access(rrbc1_pkg::CMD_WRITE, 16'h4000, 8'h02);
        send_access(rrbc1_pkg::CMD_READ,  16'h7FFF, 8'h00);
        send_access(rrbc1_pkg::CMD_WRITE, 16'h4000, 8'h03);
        send_access(rrbc1_pkg::CMD_READ,  16'h5000, 8'h00);
        send_access(rrbc1_pkg::CMD_WRITE, 16'h3000, 8'hFF);   // bank 0x7F
        send_access(rrbc1_pkg::CMD_READ,  16'h7FFF, 8'h00);
        send_access(rrbc1_pkg::CMD_WRITE, 16'h7FFF, 8'h01);   // mode 1
        send_access(rrbc1_pkg::CMD_WRITE, 16'h4000, 8'h03);   // RAM bank 3
        send_access(rrbc1_pkg::CMD_WRITE, 16'hBFFF, 8'hA5);
        send_access(rrbc1_pkg::CMD_READ,  16'hBFFF, 8'h00);
        set_bank_counts(8'd128, 3'd1);
        send_access(rrbc1_pkg::CMD_WRITE, 16'h4000, 8'h02);   // beyond the RAM, kept
        send_access(rrbc1_pkg::CMD_READ,  16'hBFFF, 8'h00);
        send_access(rrbc1_pkg::CMD_WRITE, 16'h6000, 8'h00);
    endtask

    task automatic test_receiver_backpressure();
        set_bank_counts(8'd128, 3'd4);
        hold_req = LONG_HOLD;
        random_items(60);
    endtask

    task automatic test_sender_pause();
        set_bank_counts(8'd96, 3'd2);
        random_items(40);
        wait_idle();
        random_items(40);
    endtask

    task automatic test_random_traffic(int n, logic [7:0] rom, logic [2:0] ram);
        set_bank_counts(rom, ram);
        random_items(n);
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tuser = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = rrbc1_pkg::CFG_ROM_BANK_COUNT;
        cfg_data = '0;
        idle_bursts_on = 1'b0;
        hold_req = 0;
        hold_left = 0;
        stall_left = 0;
        stall_cycles = 0;
        errors = 0;
        cur_rom_bank = 7'd1;
        sel_bits = '0;
        cur_ram_bank = '0;
        ram_on = 1'b0;
        mode = 1'b0;
        rom_count = rrbc1_pkg::ROM_COUNT_RST;
        ram_count = rrbc1_pkg::RAM_COUNT_RST;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed_cases();
        test_receiver_backpressure();
        idle_bursts_on = 1'b1;
        test_random_traffic(220, 8'd2, 3'd0);
        test_random_traffic(220, 8'd128, 3'd4);
        test_random_traffic(200, 8'd64, 3'd2);
        idle_bursts_on = 1'b0;
        test_random_traffic(150, 8'd128, 3'd1);
        idle_bursts_on = 1'b1;
        test_random_traffic(200, 8'd3, 3'd4);
        test_random_traffic(200, 8'($urandom_range(2, 128)), 3'($urandom_range(0, 4)));
        test_random_traffic(200, 8'd33, 3'd3);
        test_sender_pause();
        test_random_traffic(200, 8'($urandom_range(2, 128)), 3'($urandom_range(0, 4)));
        idle_bursts_on = 1'b0;
        test_random_traffic(250, 8'd128, 3'd4);

        wait_idle();
        repeat (8) @(posedge aclk);
        $display("Covered %0d accesses over %0d bank count settings:", n_items, n_settings);
        $display("  %0d ROM, %0d RAM, %0d open bus, %0d writes, %0d bank skips",
            n_rom, n_ram, n_open, n_write, n_bumps);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
